FILE: rtl/bscfd_pkg.sv
// Shared types and constants for the byte stream CAN frame deframer.
// No dependencies; used by every module of the block.
package bscfd_pkg;

  // Frame delimiters and limits
  localparam logic [7:0] SYNC_FIRST  = 8'hB7;
  localparam logic [7:0] SYNC_SECOND = 8'hB6;
  localparam logic [7:0] MAX_PAYLOAD = 8'd8;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_IDHI  = 6'b000100,
    PH_IDLO  = 6'b001000,
    PH_LEN   = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_e;

  // One decoded CAN data frame
  typedef struct packed {
    logic [15:0]                 id;
    logic [3:0]                  length;
    logic [STORE_DEPTH-1:0][7:0] payload;
  } frame_t;

endpackage

FILE: rtl/bscfd_parser.sv
// Input byte register and frame parser of the deframer.
// Depends on bscfd_pkg for the phase encoding and the frame type.
module bscfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                frm_valid_o,
  input  logic                frm_ready_i,
  output bscfd_pkg::frame_t   frm_o
);

  logic                                 byte_valid_q, byte_valid_d;
  logic [7:0]                           byte_q;
  bscfd_pkg::phase_e                    phase_q, phase_d;
  logic [15:0]                          id_q, id_d;
  logic [3:0]                           len_q, len_d;
  logic [3:0]                           count_q, count_d;
  logic [bscfd_pkg::STORE_DEPTH-1:0][7:0] store_q, store_d;
  logic                                 emit;
  logic                                 consume;
  logic                                 take;
  logic [3:0]                           count_inc;

  // Held byte leaves when its frame, if any, can go to the output register
  assign consume    = byte_valid_q && (!emit || frm_ready_i);
  assign in_ready_o = !byte_valid_q || consume;
  assign take       = in_valid_i && in_ready_o;
  assign count_inc  = count_q + 4'd1;

  always_comb begin
    byte_valid_d = byte_valid_q;
    if (take) begin
      byte_valid_d = 1'b1;
    end else if (consume) begin
      byte_valid_d = 1'b0;
    end
  end

  // Next-state logic for one held byte
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    count_d = count_q;
    store_d = store_q;
    emit    = 1'b0;
    if (byte_valid_q) begin
      case (phase_q)
        bscfd_pkg::PH_SYNC2: begin
          if (byte_q == bscfd_pkg::SYNC_SECOND) begin
            phase_d = bscfd_pkg::PH_IDHI;
          end
        end
        bscfd_pkg::PH_IDHI: begin
          id_d    = {byte_q, 8'h00};
          phase_d = bscfd_pkg::PH_IDLO;
        end
        bscfd_pkg::PH_IDLO: begin
          id_d    = {id_q[15:8], byte_q};
          phase_d = bscfd_pkg::PH_LEN;
        end
        bscfd_pkg::PH_LEN: begin
          if (byte_q > bscfd_pkg::MAX_PAYLOAD) begin
            phase_d = bscfd_pkg::PH_HUNT;
          end else begin
            len_d   = byte_q[3:0];
            count_d = 4'd0;
            store_d = '0;
            if (byte_q[3:0] == 4'd0) begin
              // empty frame goes out on the length byte
              emit    = 1'b1;
              phase_d = bscfd_pkg::PH_HUNT;
            end else begin
              phase_d = bscfd_pkg::PH_DATA;
            end
          end
        end
        bscfd_pkg::PH_DATA: begin
          if (count_q < 4'(bscfd_pkg::STORE_DEPTH)) begin
            store_d[count_q[bscfd_pkg::IDX_W-1:0]] = byte_q;
          end
          count_d = count_inc;
          if (count_inc >= len_q) begin
            emit    = 1'b1;
            phase_d = bscfd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_d = (byte_q == bscfd_pkg::SYNC_FIRST) ? bscfd_pkg::PH_SYNC2
                                                      : bscfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Frame request toward the output register
  assign frm_valid_o = byte_valid_q && emit;
  always_comb begin
    frm_o.id     = id_d;
    frm_o.length = len_d;
    for (int k = 0; k < bscfd_pkg::STORE_DEPTH; k++) begin
      frm_o.payload[k] = (4'(k) < len_d) ? store_d[k] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      phase_q      <= bscfd_pkg::PH_HUNT;
      id_q         <= '0;
      len_q        <= '0;
      count_q      <= '0;
      store_q      <= '0;
    end else begin
      byte_valid_q <= byte_valid_d;
      if (consume) begin
        phase_q <= phase_d;
        id_q    <= id_d;
        len_q   <= len_d;
        count_q <= count_d;
        store_q <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

FILE: rtl/bscfd_out.sv
// Result register holding one decoded frame until the receiver takes it.
// Depends on bscfd_pkg for the frame type.
module bscfd_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frm_valid_i,
  output logic              frm_ready_o,
  input  bscfd_pkg::frame_t frm_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bscfd_pkg::frame_t frame_o
);

  logic              valid_q, valid_d;
  bscfd_pkg::frame_t frame_q;
  logic              load;

  // Slot is free when empty or being emptied this cycle
  assign frm_ready_o = !valid_q || out_ready_i;
  assign load        = frm_valid_i && frm_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frm_i;
    end
  end

  assign out_valid_o = valid_q;
  assign frame_o     = frame_q;

endmodule

FILE: rtl/byte_stream_can_frame_deframer.sv
// Top level of the byte stream CAN frame deframer.
// Depends on bscfd_pkg, bscfd_parser and bscfd_out.
//
// Input channel: one received serial byte per request (rx_byte_i) with
// in_valid_i / in_ready_o. Frames are 0xB7, 0xB6, id high, id low, length,
// then length payload bytes; a length above eight drops the frame.
// Output channel: one CAN data frame per request (frame_id_o,
// frame_length_o, payload_0_o..payload_7_o) with out_valid_o / out_ready_i.
// Payload bytes at or past the length read as zero.
// Path: the last byte of a frame (the length byte for an empty frame) goes
// from the input byte register via the parser to the result register.
// Throughput: one byte per cycle unless a finished frame must wait;
// the parser is combinational between the input and result registers.
// Reset: the parser returns to hunting for 0xB7 and both registers empty.
// Stall: while a finished frame waits, bytes that do not complete a frame
// keep flowing; a byte that would complete the next frame is held in the
// input register and in_ready_o drops until the result register frees up.
module byte_stream_can_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] frame_id_o,
  output logic [3:0]  frame_length_o,
  output logic [7:0]  payload_0_o,
  output logic [7:0]  payload_1_o,
  output logic [7:0]  payload_2_o,
  output logic [7:0]  payload_3_o,
  output logic [7:0]  payload_4_o,
  output logic [7:0]  payload_5_o,
  output logic [7:0]  payload_6_o,
  output logic [7:0]  payload_7_o
);

  logic              frm_valid;
  logic              frm_ready;
  bscfd_pkg::frame_t frm;
  bscfd_pkg::frame_t frame;

  bscfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  bscfd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame)
  );

  assign frame_id_o     = frame.id;
  assign frame_length_o = frame.length;
  assign payload_0_o    = frame.payload[0];
  assign payload_1_o    = frame.payload[1];
  assign payload_2_o    = frame.payload[2];
  assign payload_3_o    = frame.payload[3];
  assign payload_4_o    = frame.payload[4];
  assign payload_5_o    = frame.payload[5];
  assign payload_6_o    = frame.payload[6];
  assign payload_7_o    = frame.payload[7];

endmodule
